[hdl/lpi_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// Line pixel interpolator package
// Coordinate width, request and pixel payload types, and sequencer states.
// ---------------------------------------------------------------------------
package lpi_pkg;

	localparam int COORD_BITS = 6;

	typedef logic [COORD_BITS-1:0] coord_t;

	typedef struct packed {
		coord_t x_start;
		coord_t y_start;
		coord_t x_end;
		coord_t y_end;
	} seg_t;

	typedef struct packed {
		coord_t pixel_x;
		coord_t pixel_y;
		logic   last;
	} pix_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SETUP,
		ST_RUN
	} state_t;

endpackage
`default_nettype wire

[hdl/lpi_seg_if.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// Segment request channel
// Valid/ready channel that carries the two endpoints of one line segment.
// ---------------------------------------------------------------------------
interface lpi_seg_if;
	import lpi_pkg::*;

	logic valid;
	logic ready;
	seg_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[hdl/lpi_pix_if.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// Pixel result channel
// Valid/ready channel that carries one rasterized pixel and its last flag.
// ---------------------------------------------------------------------------
interface lpi_pix_if;
	import lpi_pkg::*;

	logic valid;
	logic ready;
	pix_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[hdl/line_pixel_interpolator_unit.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// Line pixel interpolator
// Walks a line segment along its major axis and emits one pixel per step.
// ---------------------------------------------------------------------------
//  channel  dir  handshake      payload
//  seg      in   valid/ready    x_start, y_start, x_end, y_end
//  pix      out  valid/ready    pixel_x, pixel_y, last
//
// A request with major span D is accepted in idle, then a setup state sets up
// spans and the walk range, and the run state emits D + 1 pixels.
// The minor coordinate comes from a quotient/remainder accumulator that
// advances once per accepted pixel before the last. A stalled pixel holds
// the walk; no request is taken until the last pixel leaves. Reset returns
// the sequencer to idle.
// ---------------------------------------------------------------------------
module line_pixel_interpolator_unit (
	input  logic        clk,
	input  logic        arst_n,
	lpi_seg_if.sink     seg,
	lpi_pix_if.source   pix
);
	import lpi_pkg::*;

	localparam int CB = COORD_BITS;

	state_t           state_q;
	state_t           state_d;
	seg_t             seg_q;
	logic             x_major_q;
	logic             neg_maj_q;
	logic             neg_min_q;
	coord_t           m_q;
	coord_t           hi_q;
	coord_t           mn_q;
	coord_t           dist_q;
	coord_t           step_q;
	coord_t           quo_q;
	coord_t           rem_q;

	logic signed [CB:0] dx;
	logic signed [CB:0] dy;
	logic [CB:0]        adx_w;
	logic [CB:0]        ady_w;
	coord_t             adx;
	coord_t             ady;
	logic               x_major;
	logic               is_last;
	logic               step_en;
	logic [CB:0]        acc;
	logic [CB:0]        acc_fix;
	logic               wrap;
	logic [CB:0]        minor_w;
	coord_t             minor;

	assign dx = $signed({1'b0, seg_q.x_end}) - $signed({1'b0, seg_q.x_start});
	assign dy = $signed({1'b0, seg_q.y_end}) - $signed({1'b0, seg_q.y_start});
	assign adx_w = dx[CB] ? -dx : dx;
	assign ady_w = dy[CB] ? -dy : dy;
	assign adx = adx_w[CB-1:0];
	assign ady = ady_w[CB-1:0];
	assign x_major = adx >= ady;

	assign is_last = m_q == hi_q;
	assign step_en = (state_q == ST_RUN) && pix.ready && !is_last;

	// Remainder update: step forward adds the minor span, step backward
	// removes it, and a wrap past the major span moves the quotient by one.
	always_comb begin
		if (neg_maj_q) begin
			acc     = {1'b0, rem_q} - {1'b0, step_q};
			wrap    = acc[CB];
			acc_fix = acc + {1'b0, dist_q};
		end else begin
			acc     = {1'b0, rem_q} + {1'b0, step_q};
			wrap    = acc >= {1'b0, dist_q};
			acc_fix = acc - {1'b0, dist_q};
		end
	end

	assign minor_w = neg_min_q ? {1'b0, mn_q} - {1'b0, quo_q} : {1'b0, mn_q} + {1'b0, quo_q};
	assign minor = minor_w[CB-1:0];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (seg.valid) state_d = ST_SETUP;
			end
			ST_SETUP: begin
				state_d = ST_RUN;
			end
			ST_RUN: begin
				if (pix.ready && is_last) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		seg.ready        = state_q == ST_IDLE;
		pix.valid        = state_q == ST_RUN;
		pix.data.pixel_x = x_major_q ? m_q : minor;
		pix.data.pixel_y = x_major_q ? minor : m_q;
		pix.data.last    = is_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (seg.valid && seg.ready) begin
			seg_q <= seg.data;
		end
		if (state_q == ST_SETUP) begin
			x_major_q <= x_major;
			rem_q     <= '0;
			if (x_major) begin
				neg_maj_q <= dx[CB];
				neg_min_q <= dy[CB];
				mn_q      <= seg_q.y_start;
				dist_q    <= adx;
				step_q    <= ady;
				m_q       <= dx[CB] ? seg_q.x_end : seg_q.x_start;
				hi_q      <= dx[CB] ? seg_q.x_start : seg_q.x_end;
				quo_q     <= dx[CB] ? ady : '0;
			end else begin
				neg_maj_q <= dy[CB];
				neg_min_q <= dx[CB];
				mn_q      <= seg_q.x_start;
				dist_q    <= ady;
				step_q    <= adx;
				m_q       <= dy[CB] ? seg_q.y_end : seg_q.y_start;
				hi_q      <= dy[CB] ? seg_q.y_start : seg_q.y_end;
				quo_q     <= dy[CB] ? adx : '0;
			end
		end else if (step_en) begin
			m_q <= m_q + 1'b1;
			if (wrap) begin
				rem_q <= acc_fix[CB-1:0];
				quo_q <= neg_maj_q ? quo_q - 1'b1 : quo_q + 1'b1;
			end else begin
				rem_q <= acc[CB-1:0];
			end
		end
	end

endmodule
`default_nettype wire

[hdl/lpi_checker.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// Line pixel interpolator checker
// Port-level assertions on request and pixel sequencing, bound to the top.
// ---------------------------------------------------------------------------
module lpi_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          seg_valid,
	input logic          seg_ready,
	input logic          pix_valid,
	input logic          pix_ready,
	input lpi_pkg::pix_t pix_data
);
	import lpi_pkg::*;

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(seg_ready && pix_valid))
		else $error("request taken while a pixel is pending");

	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		(seg_valid && seg_ready) |=> (!seg_ready && !pix_valid))
		else $error("no setup cycle after an accepted request");

	a_end_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_valid && pix_ready && pix_data.last) |=> !pix_valid)
		else $error("pixel emitted after the last pixel");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_valid && !pix_ready) |=> (pix_valid && $stable(pix_data)))
		else $error("stalled pixel changed");

endmodule

bind line_pixel_interpolator_unit lpi_checker u_lpi_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.seg_valid (seg.valid),
	.seg_ready (seg.ready),
	.pix_valid (pix.valid),
	.pix_ready (pix.ready),
	.pix_data  (pix.data)
);
`default_nettype wire
